[hw/rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and helpers for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int HANDLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 24;
    localparam int TAG_W      = 8;

    // request codes
    localparam logic [1:0] REQ_ARM_ONCE     = 2'd0;
    localparam logic [1:0] REQ_ARM_PERIODIC = 2'd1;
    localparam logic [1:0] REQ_CANCEL       = 2'd2;
    localparam logic [1:0] REQ_POLL         = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_FULL        = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND   = 2'd2;
    localparam logic [1:0] STS_NOTHING_DUE = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        op_t                 op;
        entry_t              ins;
        logic [HANDLE_W-1:0] target;
    } cmd_t;

    localparam entry_t ENTRY_EMPTY = '0;

    // a is earlier than b when the wrapping difference is negative
    function automatic logic earlier(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

[hw/rtl/deadline_timer_queue.sv]
// Sequence: an arm passes S_ARM into the output register; a poll passes S_POLL,
//   and S_REARM as well when a periodic entry is re-armed; a cancel stays in S_CANCEL while entries still match.
// Flow: one request at a time; a result waiting in the output register does not
//   hold the input.
// Reset (synchronous, active low) clears all slot valid bits and the handle
//   counter at once; no clearing pass.
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer table kept sorted by deadline in a chain of cells; arm, cancel, poll.
// ----------------------------------------------------------------------------
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic [PERIOD_W-1:0] s_delay_ms,
    input  logic [TAG_W-1:0]    s_action_tag,
    input  logic [HANDLE_W-1:0] s_target_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [HANDLE_W-1:0] m_new_handle,
    output logic                m_fired,
    output logic [HANDLE_W-1:0] m_fired_handle,
    output logic [TAG_W-1:0]    m_fired_tag
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_CANCEL,
        S_POLL,
        S_REARM
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          req_reg, req_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PERIOD_W-1:0] delay_reg, delay_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [HANDLE_W-1:0] target_reg, target_next;
    logic [HANDLE_W-1:0] counter_reg, counter_next;
    logic                found_reg, found_next;
    entry_t              fire_reg, fire_next;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [HANDLE_W-1:0] m_new_handle_reg, m_new_handle_next;
    logic                m_fired_reg, m_fired_next;
    logic [HANDLE_W-1:0] m_fired_handle_reg, m_fired_handle_next;
    logic [TAG_W-1:0]    m_fired_tag_reg, m_fired_tag_next;

    cmd_t                cmd;
    logic                carry0;
    entry_t              entries [TABLE_DEPTH];
    logic [TABLE_DEPTH:0] carry;
    logic [TABLE_DEPTH-1:0] valid_vec;

    logic                out_free;
    logic                table_full;
    logic                due;
    logic                arm_done;

    // ---------------- cell chain ----------------
    assign carry[0] = carry0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        if (i == 0) begin : g_first
            assign prev_e = ENTRY_EMPTY;
        end else begin : g_mid_prev
            assign prev_e = entries[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign next_e = ENTRY_EMPTY;
        end else begin : g_mid_next
            assign next_e = entries[i+1];
        end

        dtq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .carry_in   (carry[i]),
            .entry      (entries[i]),
            .carry_out  (carry[i+1])
        );

        assign valid_vec[i] = entries[i].valid;
    end

    assign table_full = entries[TABLE_DEPTH-1].valid;
    assign due        = entries[0].valid && !earlier(now_reg, entries[0].deadline);
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_new_handle   = m_new_handle_reg;
    assign m_fired        = m_fired_reg;
    assign m_fired_handle = m_fired_handle_reg;
    assign m_fired_tag    = m_fired_tag_reg;

    // ---------------- control ----------------
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        now_next     = now_reg;
        delay_next   = delay_reg;
        tag_next     = tag_reg;
        target_next  = target_reg;
        counter_next = counter_reg;
        found_next   = found_reg;
        fire_next    = fire_reg;

        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_new_handle_next   = m_new_handle_reg;
        m_fired_next        = m_fired_reg;
        m_fired_handle_next = m_fired_handle_reg;
        m_fired_tag_next    = m_fired_tag_reg;

        cmd        = '{op: OP_HOLD, ins: ENTRY_EMPTY, target: target_reg};
        carry0     = 1'b0;
        arm_done   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    now_next    = s_now_ms;
                    delay_next  = s_delay_ms;
                    tag_next    = s_action_tag;
                    target_next = s_target_handle;
                    found_next  = 1'b0;
                    unique case (s_req_type)
                        REQ_ARM_ONCE, REQ_ARM_PERIODIC: state_next = S_ARM;
                        REQ_CANCEL:                     state_next = S_CANCEL;
                        default:                        state_next = S_POLL;
                    endcase
                end
            end
            S_ARM: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_fired_next        = 1'b0;
                    m_fired_handle_next = '0;
                    m_fired_tag_next    = '0;
                    if (table_full) begin
                        m_status_next     = STS_FULL;
                        m_new_handle_next = '0;
                    end else begin
                        arm_done          = 1'b1;
                        cmd.op            = OP_INSERT;
                        cmd.ins.valid     = 1'b1;
                        cmd.ins.handle    = counter_reg;
                        cmd.ins.deadline  = now_reg + TIME_W'(delay_reg);
                        cmd.ins.period    = (req_reg == REQ_ARM_PERIODIC) ? delay_reg : '0;
                        cmd.ins.tag       = tag_reg;
                        counter_next      = counter_reg + 1'b1;
                        m_status_next     = STS_OK;
                        m_new_handle_next = counter_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CANCEL: begin
                // one matching entry leaves the chain per cycle
                cmd.op = OP_REMOVE;
                if (carry[TABLE_DEPTH]) begin
                    found_next = 1'b1;
                end else if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = found_reg ? STS_OK : STS_NOT_FOUND;
                    m_new_handle_next   = '0;
                    m_fired_next        = 1'b0;
                    m_fired_handle_next = '0;
                    m_fired_tag_next    = '0;
                    state_next          = S_IDLE;
                end
            end
            S_POLL: begin
                if (due && entries[0].period != '0) begin
                    cmd.op     = OP_REMOVE;
                    carry0     = 1'b1;
                    fire_next  = entries[0];
                    state_next = S_REARM;
                end else if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_new_handle_next = '0;
                    if (due) begin
                        cmd.op              = OP_REMOVE;
                        carry0              = 1'b1;
                        m_status_next       = STS_OK;
                        m_fired_next        = 1'b1;
                        m_fired_handle_next = entries[0].handle;
                        m_fired_tag_next    = entries[0].tag;
                    end else begin
                        m_status_next       = STS_NOTHING_DUE;
                        m_fired_next        = 1'b0;
                        m_fired_handle_next = '0;
                        m_fired_tag_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REARM: begin
                if (out_free) begin
                    cmd.op              = OP_INSERT;
                    cmd.ins             = fire_reg;
                    cmd.ins.valid       = 1'b1;
                    cmd.ins.deadline    = now_reg + TIME_W'(fire_reg.period);
                    m_valid_next        = 1'b1;
                    m_status_next       = STS_OK;
                    m_new_handle_next   = '0;
                    m_fired_next        = 1'b1;
                    m_fired_handle_next = fire_reg.handle;
                    m_fired_tag_next    = fire_reg.tag;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            counter_reg <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg            <= req_next;
        now_reg            <= now_next;
        delay_reg          <= delay_next;
        tag_reg            <= tag_next;
        target_reg         <= target_next;
        fire_reg           <= fire_next;
        m_status_reg       <= m_status_next;
        m_new_handle_reg   <= m_new_handle_next;
        m_fired_reg        <= m_fired_next;
        m_fired_handle_reg <= m_fired_handle_next;
        m_fired_tag_reg    <= m_fired_tag_next;
    end

`ifndef SYNTHESIS
    // live slots always form a solid run from slot 0
    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + (TABLE_DEPTH+1)'(1)))
        else $error("timer chain has a hole");

    a_handle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        arm_done |=> counter_reg == $past(counter_reg) + 1'b1)
        else $error("handle counter did not advance on arm");

    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_fired_reg |-> m_status_reg == STS_OK)
        else $error("fired result without ok status");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ARM) && table_full && out_free |=> m_status_reg == STS_FULL)
        else $error("full table not reported");
`endif

endmodule

[hw/rtl/dtq_cell.sv]
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted timer chain. Takes the new entry, its upper
// neighbor (shift down on insert) or its lower neighbor (shift up on remove).
// ----------------------------------------------------------------------------
module dtq_cell
    import dtq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd,
    input  entry_t prev_entry,
    input  entry_t next_entry,
    input  logic   carry_in,
    output entry_t entry,
    output logic   carry_out
);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;
    logic   hit;

    assign entry = '{valid: valid_reg, handle: data_reg.handle,
                     deadline: data_reg.deadline, period: data_reg.period,
                     tag: data_reg.tag};

    always_comb begin
        unique case (cmd.op)
            OP_INSERT: hit = !valid_reg || earlier(cmd.ins.deadline, data_reg.deadline);
            OP_REMOVE: hit = valid_reg && (data_reg.handle == cmd.target);
            default:   hit = 1'b0;
        endcase
    end

    // carry marks that the insert or remove point lies above this cell
    assign carry_out = carry_in | hit;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            OP_INSERT: begin
                if (carry_in) begin
                    data_next  = prev_entry;
                    valid_next = prev_entry.valid;
                end else if (hit) begin
                    data_next  = cmd.ins;
                    valid_next = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (carry_in || hit) begin
                    data_next  = next_entry;
                    valid_next = next_entry.valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

[bench/tb_deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue
// Self-checking bench for the deadline timer queue. A tracker class keeps its
// own sorted copy of the timer table, predicts the result of every request
// taken by the block and compares each result transfer field by field. The
// stimulus is a short directed part, a random mix of arm, cancel and poll
// traffic around a moving time base, and a drain of the table by cancels.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] new_handle;
        logic                fired;
        logic [HANDLE_W-1:0] fired_handle;
        logic [TAG_W-1:0]    fired_tag;
    } timer_result_t;

    class timer_queue_tracker;
        entry_t              slots[TABLE_DEPTH];
        int                  live;
        logic [HANDLE_W-1:0] next_handle;
        timer_result_t       awaited[$];
        int unsigned         mismatches;

        function new();
            live        = 0;
            next_handle = '0;
            mismatches  = 0;
        endfunction

        function bit is_before(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W-1:0] diff;
            diff = a - b;
            return diff[TIME_W-1];
        endfunction

        // new entry goes behind everything not later than itself
        function void place(entry_t e);
            int pos;
            pos = 0;
            while (pos < live && !is_before(e.deadline, slots[pos].deadline))
                pos++;
            for (int i = live; i > pos; i--)
                slots[i] = slots[i-1];
            slots[pos] = e;
            live++;
        endfunction

        function void drop(int pos);
            for (int i = pos; i < live - 1; i++)
                slots[i] = slots[i+1];
            live--;
        endfunction

        function timer_result_t predict(logic [1:0] req, logic [TIME_W-1:0] now,
                                        logic [PERIOD_W-1:0] delay, logic [TAG_W-1:0] tag,
                                        logic [HANDLE_W-1:0] target);
            timer_result_t r;
            entry_t        e;
            int            i;
            bit            hit;
            r = '0;
            case (req)
                REQ_ARM_ONCE, REQ_ARM_PERIODIC: begin
                    if (live >= TABLE_DEPTH) begin
                        r.status = STS_FULL;
                    end else begin
                        e          = '0;
                        e.valid    = 1'b1;
                        e.handle   = next_handle;
                        e.deadline = now + delay;
                        e.period   = (req == REQ_ARM_PERIODIC) ? delay : '0;
                        e.tag      = tag;
                        r.status     = STS_OK;
                        r.new_handle = next_handle;
                        next_handle  = next_handle + 1'b1;
                        place(e);
                    end
                end
                REQ_CANCEL: begin
                    i   = 0;
                    hit = 1'b0;
                    while (i < live) begin
                        if (slots[i].handle == target) begin
                            drop(i);
                            hit = 1'b1;
                        end else begin
                            i++;
                        end
                    end
                    r.status = hit ? STS_OK : STS_NOT_FOUND;
                end
                REQ_POLL: begin
                    if (live == 0 || is_before(now, slots[0].deadline)) begin
                        r.status = STS_NOTHING_DUE;
                    end else begin
                        e = slots[0];
                        drop(0);
                        // periodic entries come back relative to the poll time
                        if (e.period != '0) begin
                            e.deadline = now + e.period;
                            place(e);
                        end
                        r.status       = STS_OK;
                        r.fired        = 1'b1;
                        r.fired_handle = e.handle;
                        r.fired_tag    = e.tag;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [1:0] req, logic [TIME_W-1:0] now,
                                   logic [PERIOD_W-1:0] delay, logic [TAG_W-1:0] tag,
                                   logic [HANDLE_W-1:0] target);
            awaited.push_back(predict(req, now, delay, tag, target));
        endfunction

        function void report(string what, timer_result_t exp, timer_result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: exp sts %0d new %h fired %0d fh %h ftag %h",
                         $realtime, what, exp.status, exp.new_handle, exp.fired,
                         exp.fired_handle, exp.fired_tag);
                $display("        got sts %0d new %h fired %0d fh %h ftag %h",
                         got.status, got.new_handle, got.fired, got.fired_handle,
                         got.fired_tag);
            end
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t exp;
            if (awaited.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                exp = awaited[0];
                awaited.delete(0);
                if (got.status !== exp.status || got.new_handle !== exp.new_handle ||
                    got.fired !== exp.fired || got.fired_handle !== exp.fired_handle ||
                    got.fired_tag !== exp.fired_tag)
                    report("result mismatch", exp, got);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [HANDLE_W-1:0] pick_handle();
            if (live == 0)
                return HANDLE_W'($urandom);
            return slots[$urandom_range(0, live - 1)].handle;
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_req_type;
    logic [TIME_W-1:0]   s_now_ms;
    logic [PERIOD_W-1:0] s_delay_ms;
    logic [TAG_W-1:0]    s_action_tag;
    logic [HANDLE_W-1:0] s_target_handle;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [HANDLE_W-1:0] m_new_handle;
    logic                m_fired;
    logic [HANDLE_W-1:0] m_fired_handle;
    logic [TAG_W-1:0]    m_fired_tag;

    timer_queue_tracker queue_tracker;
    bit                 no_gaps;
    int unsigned        cycles;

    deadline_timer_queue #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_now_ms       (s_now_ms),
        .s_delay_ms     (s_delay_ms),
        .s_action_tag   (s_action_tag),
        .s_target_handle(s_target_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_new_handle   (m_new_handle),
        .m_fired        (m_fired),
        .m_fired_handle (m_fired_handle),
        .m_fired_tag    (m_fired_tag)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_request(input logic [1:0] req, input logic [TIME_W-1:0] now,
                                input logic [PERIOD_W-1:0] delay,
                                input logic [TAG_W-1:0] tag,
                                input logic [HANDLE_W-1:0] target);
        int unsigned gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 8)
            gap = $urandom_range(1, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_now_ms        <= now;
        s_delay_ms      <= delay;
        s_action_tag    <= tag;
        s_target_handle <= target;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        queue_tracker.note_request(req, now, delay, tag, target);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (queue_tracker.pending() != 0)
            @(posedge aclk);
    endtask

    // result side: random back-pressure, check on every transfer
    initial begin
        timer_result_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.status       = m_status;
                got.new_handle   = m_new_handle;
                got.fired        = m_fired;
                got.fired_handle = m_fired_handle;
                got.fired_tag    = m_fired_tag;
                queue_tracker.check_result(got);
            end
            m_ready <= no_gaps || ($urandom_range(0, 99) >= 8);
        end
    end

    initial begin
        logic [TIME_W-1:0]   wall_ms;
        logic [PERIOD_W-1:0] span;
        logic [HANDLE_W-1:0] sentinel;
        int unsigned         roll;

        queue_tracker   = new();
        no_gaps         = 1'b0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_req_type      <= REQ_POLL;
        s_now_ms        <= '0;
        s_delay_ms      <= '0;
        s_action_tag    <= '0;
        s_target_handle <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, wrapping deadline, equal deadlines, zero period
        send_request(REQ_POLL, 32'd0, '0, '0, '0);
        send_request(REQ_CANCEL, 32'd0, '0, '0, 16'hFFFF);
        send_request(REQ_ARM_ONCE, 32'd0, 24'd0, 8'h00, 16'h0000);
        send_request(REQ_ARM_PERIODIC, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 16'hFFFF);
        send_request(REQ_ARM_PERIODIC, 32'd100, 24'd0, 8'h5A, 16'h0000);
        send_request(REQ_ARM_ONCE, 32'd50, 24'd50, 8'hA5, 16'h0000);
        send_request(REQ_POLL, 32'd99, 24'hFF_FFFF, 8'hFF, 16'hFFFF);
        send_request(REQ_POLL, 32'd100, '0, '0, '0);
        send_request(REQ_POLL, 32'd100, '0, '0, '0);
        send_request(REQ_POLL, 32'h00FF_FFFE, '0, '0, '0);
        send_request(REQ_CANCEL, 32'hFFFF_FFFF, '0, '0, 16'd1);
        // fill the table, then one more arm to hit the full status
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_request((i % 2 == 0) ? REQ_ARM_ONCE : REQ_ARM_PERIODIC, 32'd1000,
                         PERIOD_W'((i * 37) % 200), TAG_W'(i * 13), HANDLE_W'(i));
        wait_idle();

        // random mix around a moving time base
        wall_ms = 32'd1000;
        for (int n = 0; n < 720; n++) begin
            no_gaps = (n >= 250 && n < 400);
            roll    = $urandom_range(0, 99);
            if (roll < 42) begin
                roll = $urandom_range(0, 99);
                span = (roll < 10) ? '0 :
                       (roll < 90) ? PERIOD_W'($urandom_range(1, 80)) : PERIOD_W'($urandom);
                send_request($urandom_range(0, 1) ? REQ_ARM_PERIODIC : REQ_ARM_ONCE,
                             wall_ms, span, TAG_W'($urandom), HANDLE_W'($urandom));
            end else if (roll < 72) begin
                wall_ms = wall_ms + $urandom_range(0, 30);
                send_request(REQ_POLL, wall_ms, PERIOD_W'($urandom), TAG_W'($urandom),
                             HANDLE_W'($urandom));
            end else if (roll < 92) begin
                send_request(REQ_CANCEL, wall_ms, PERIOD_W'($urandom), TAG_W'($urandom),
                             ($urandom_range(0, 99) < 85) ? queue_tracker.pick_handle()
                                                          : HANDLE_W'($urandom));
            end else if (roll < 95) begin
                // poll at an arbitrary time, time base untouched
                send_request(REQ_POLL, TIME_W'($urandom), PERIOD_W'($urandom),
                             TAG_W'($urandom), HANDLE_W'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                else
                    wall_ms = wall_ms + $urandom_range(0, 32'h00FF_FFFF);
                send_request(REQ_POLL, wall_ms, PERIOD_W'($urandom), TAG_W'($urandom),
                             HANDLE_W'($urandom));
            end
        end
        no_gaps = 1'b0;
        wait_idle();

        // empty the table, then a few requests around one parked timer
        while (queue_tracker.live != 0)
            send_request(REQ_CANCEL, wall_ms, '0, '0, queue_tracker.slots[0].handle);
        sentinel = queue_tracker.next_handle;
        send_request(REQ_ARM_PERIODIC, wall_ms, 24'hFF_FFFF, 8'h3C, '0);
        send_request(REQ_ARM_ONCE, wall_ms, 24'd3, 8'hC3, '0);
        send_request(REQ_CANCEL, wall_ms, '0, '0, sentinel);
        send_request(REQ_CANCEL, wall_ms, '0, '0, sentinel);
        send_request(REQ_POLL, wall_ms + 32'd10, '0, '0, '0);
        wait_idle();
        repeat (40) @(posedge aclk);

        if (queue_tracker.mismatches == 0 && queue_tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[deadline_timer_queue.f]
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_cell.sv
hw/rtl/deadline_timer_queue.sv
bench/tb_deadline_timer_queue.sv
